[rtl/core/mm2h_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, datapath operation codes and command/status structs for
// the MurmurHash2 stream hasher. No dependencies.
package mm2h_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'd31;
    localparam logic [2:0]  FULL_BYTES  = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_K1,
        OP_K2,
        OP_HF,
        OP_TAIL,
        OP_FIN1,
        OP_FIN2
    } t_op;

    typedef struct packed {
        t_op  op;
        logic use_seed;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

[rtl/core/mm2h_dp.sv]
`timescale 1ns / 1ps
// Datapath of the MurmurHash2 stream hasher: seed, running hash, word and
// result registers around one shared 32x32 multiplier. Uses mm2h_pkg.
module mm2h_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mm2h_pkg::t_cmd   i_cmd,
    output mm2h_pkg::t_status o_status,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_wdata,
    input  logic [31:0]      i_key_word,
    input  logic [2:0]       i_byte_count,
    input  logic [30:0]      i_key_length,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [31:0]      o_hash_value
);

    logic [31:0] r_seed;
    logic [31:0] r_h;
    logic [31:0] r_k;
    logic [1:0]  r_cnt;
    logic [31:0] r_out;
    logic        r_ov;

    logic [31:0] tail_mask;
    logic [31:0] mul_in;
    logic [63:0] mul_full;
    logic [31:0] mul_lo;
    logic [31:0] h_start;

    always_comb begin
        case (r_cnt)
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            2'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase
    end

    always_comb begin
        unique case (i_cmd.op)
            mm2h_pkg::OP_K1,
            mm2h_pkg::OP_K2:   mul_in = r_k;
            mm2h_pkg::OP_TAIL: mul_in = r_h ^ (r_k & tail_mask);
            mm2h_pkg::OP_FIN1: mul_in = r_h ^ (r_h >> mm2h_pkg::FIN_SHIFT_A);
            default:           mul_in = r_h;
        endcase
    end

    assign mul_full = 64'(mul_in) * 64'(mm2h_pkg::MIX_MUL);
    assign mul_lo   = mul_full[31:0];
    assign h_start  = r_seed ^ {1'b0, i_key_length};

    assign o_status.out_free = !r_ov || !i_out_stall;
    assign o_out_valid       = r_ov;
    assign o_hash_value      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= mm2h_pkg::SEED_RESET;
            r_h    <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (i_cmd.op == mm2h_pkg::OP_FIN2) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (i_cmd.op)
                mm2h_pkg::OP_LOAD: begin
                    if (i_cmd.use_seed) begin
                        r_h <= h_start;
                    end
                end
                mm2h_pkg::OP_HF:   r_h <= mul_lo ^ r_k;
                mm2h_pkg::OP_TAIL,
                mm2h_pkg::OP_FIN1: r_h <= mul_lo;
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            mm2h_pkg::OP_LOAD: begin
                r_k   <= i_key_word;
                r_cnt <= i_byte_count[1:0];
            end
            mm2h_pkg::OP_K1:   r_k <= mul_lo ^ (mul_lo >> mm2h_pkg::MIX_SHIFT);
            mm2h_pkg::OP_K2:   r_k <= mul_lo;
            mm2h_pkg::OP_FIN2: r_out <= r_h ^ (r_h >> mm2h_pkg::FIN_SHIFT_B);
            default: begin
            end
        endcase
    end

    a_fin2_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == mm2h_pkg::OP_FIN2 |=> r_ov)
        else $error("result not flagged after final step");

    a_valid_from_fin2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(i_cmd.op == mm2h_pkg::OP_FIN2))
        else $error("result appeared without final step");

    a_seed_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == mm2h_pkg::OP_LOAD && i_cmd.use_seed) |=> r_h == $past(h_start))
        else $error("hash not started from seed and length");

endmodule

[rtl/core/mm2h_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the MurmurHash2 stream hasher: sequences the mix and
// finalize steps of the datapath per request. Uses mm2h_pkg.
module mm2h_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_byte_count,
    input  logic              i_last_word,
    output mm2h_pkg::t_cmd    o_cmd,
    input  mm2h_pkg::t_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_K1,
        S_K2,
        S_HF,
        S_TAIL,
        S_FIN1,
        S_FIN2
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_inside;
    logic   r_last;
    logic   accept;

    assign o_in_stall = r_state != S_IDLE;
    assign accept     = i_in_valid && r_state == S_IDLE;

    always_comb begin
        o_cmd.use_seed = !r_inside;
        unique case (r_state)
            S_IDLE:  o_cmd.op = accept ? mm2h_pkg::OP_LOAD : mm2h_pkg::OP_NONE;
            S_K1:    o_cmd.op = mm2h_pkg::OP_K1;
            S_K2:    o_cmd.op = mm2h_pkg::OP_K2;
            S_HF:    o_cmd.op = mm2h_pkg::OP_HF;
            S_TAIL:  o_cmd.op = mm2h_pkg::OP_TAIL;
            S_FIN1:  o_cmd.op = mm2h_pkg::OP_FIN1;
            S_FIN2:  o_cmd.op = i_status.out_free ? mm2h_pkg::OP_FIN2 : mm2h_pkg::OP_NONE;
            default: o_cmd.op = mm2h_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_byte_count >= mm2h_pkg::FULL_BYTES) begin
                        n_state = S_K1;
                    end else if (i_byte_count != 3'd0) begin
                        n_state = S_TAIL;
                    end else if (i_last_word) begin
                        n_state = S_FIN1;
                    end
                end
            end
            S_K1:   n_state = S_K2;
            S_K2:   n_state = S_HF;
            S_HF,
            S_TAIL: n_state = r_last ? S_FIN1 : S_IDLE;
            S_FIN1: n_state = S_FIN2;
            S_FIN2: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_inside <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_inside <= !i_last_word;
                r_last   <= i_last_word;
            end
        end
    end

    a_full_starts_k1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_byte_count >= mm2h_pkg::FULL_BYTES) |=> r_state == S_K1)
        else $error("full word did not start mixing");

    a_fin2_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN2 && !i_status.out_free) |=> r_state == S_FIN2)
        else $error("result dropped while output busy");

    a_after_hf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HF |=> (r_state == S_FIN1 || r_state == S_IDLE))
        else $error("bad step after hash combine");

    a_last_closes_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_word) |=> !r_inside)
        else $error("key left open after last request");

endmodule

[rtl/core/murmur2_hash_stream.sv]
`timescale 1ns / 1ps
// Top level of the MurmurHash2 (32-bit) stream hasher.
// Depends on mm2h_pkg, mm2h_ctrl and mm2h_dp.
//
// Usage: a key arrives as a series of input requests (i_in_valid / o_in_stall)
// carrying a little-endian word, its byte count, a last flag and, on the first
// request of a key, the total key length. The request with i_last_word set
// produces one output request (o_out_valid / i_out_stall) with the hash.
// The user must write the seed (i_cfg_we / i_cfg_wdata) only while the block
// is idle; the block itself does not enforce this.
// Rate: one request at a time through a shared 32x32 multiplier. A request
// with zero bytes only loads, a 1 to 3 byte tail adds a tail step, and a full
// word runs two key multiplies and one hash multiply; a last request adds the
// finalization steps FIN1 and FIN2. The hash leaves the output register in the
// cycle after the final step.
//
// Reset (synchronous, active low) sets the seed to 31, clears the running
// hash and output valid, and waits for the first word of a key. While the
// receiver stalls, the finished hash holds in the output register; the next
// key's words are still taken, and only a second result waits for the slot.
module murmur2_hash_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_key_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    input  logic [30:0] i_key_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value
);

    mm2h_pkg::t_cmd    cmd;
    mm2h_pkg::t_status status;

    mm2h_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_byte_count (i_byte_count),
        .i_last_word  (i_last_word),
        .o_cmd        (cmd),
        .i_status     (status)
    );

    mm2h_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_key_word   (i_key_word),
        .i_byte_count (i_byte_count),
        .i_key_length (i_key_length),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_value (o_hash_value)
    );

endmodule
